// ----- rtl/rlab_pkg.sv -----
// Shared constants, types and coefficient tables for the RGB to l-alpha-beta pipeline.
`default_nettype none
package rlab_pkg;

  // Output fraction bits and internal log precision
  localparam int FRAC_BITS = 12;
  localparam int LOG_FRAC  = 24;
  localparam int K_SHIFT   = LOG_FRAC - FRAC_BITS;

  localparam int CH_W   = 16;  // input channel width
  localparam int PIX_W  = 8;   // clamped channel
  localparam int RESP_W = 22;  // cone response, scaled by 10000
  localparam int EXP_W  = 5;   // top-bit index of a response
  localparam int MANT_W = 31;  // Q1.30 mantissa
  localparam int SQ_N   = LOG_FRAC;
  localparam int L2_W   = EXP_W + LOG_FRAC;
  localparam int LOG_W  = 28;  // signed Q.24 log10
  localparam int SUM_W  = 44;  // mixed sums before scaling
  localparam int NQ_W   = 29;  // rounded quotient numerator
  localparam int RCP_SH = 43;
  localparam int Q_W    = 16;

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
  localparam logic [29:0] RCP_10000   = 30'd879609303;

  localparam int unsigned LMS_C [3][3] = '{'{3811, 5783,  402},
                                           '{1967, 7244,  782},
                                           '{ 241, 1288, 8444}};

  localparam int C_L  = 5774;
  localparam int C_A1 = 4082;
  localparam int C_A2 = 8165;
  localparam int C_B  = 7071;

  localparam logic [SUM_W-1:0] HALF_D = SUM_W'(5000 * (2 ** K_SHIFT));
  localparam logic [SUM_W-1:0] CAP_N  = SUM_W'(32768 * 10000);

  localparam logic signed [LOG_W-1:0] LOG_OFFS = LOG_W'(4 * (2 ** LOG_FRAC));
  localparam logic signed [LOG_W-1:0] LOG_ZERO = -LOG_W'(2 * (2 ** LOG_FRAC));

  // Valid bit and error flag travelling with each item
  typedef struct packed {
    logic vld;
    logic err;
  } tag_t;

endpackage
`default_nettype wire

// ----- rtl/rlab_lms.sv -----
// Channel clamp and RGB to LMS matrix, one register stage.
`default_nettype none
module rlab_lms (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  rlab_pkg::tag_t                         tag_i,
  input  wire  [rlab_pkg::CH_W-1:0]              red_i,
  input  wire  [rlab_pkg::CH_W-1:0]              green_i,
  input  wire  [rlab_pkg::CH_W-1:0]              blue_i,
  output rlab_pkg::tag_t                         tag_o,
  output logic [2:0][rlab_pkg::RESP_W-1:0]       resp_o
);

  logic [2:0][rlab_pkg::PIX_W-1:0]   pix;
  logic [2:0][rlab_pkg::CH_W-1:0]    raw;
  logic [2:0][rlab_pkg::RESP_W-1:0]  resp_d;
  rlab_pkg::tag_t                    tag_q;

  assign raw = {blue_i, green_i, red_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (raw[c][rlab_pkg::CH_W-1]) begin
        pix[c] = '0;
      end else if (|raw[c][rlab_pkg::CH_W-2:rlab_pkg::PIX_W]) begin
        pix[c] = '1;
      end else begin
        pix[c] = raw[c][rlab_pkg::PIX_W-1:0];
      end
    end
    for (int l = 0; l < 3; l++) begin
      resp_d[l] = rlab_pkg::RESP_W'(pix[0]) * rlab_pkg::RESP_W'(rlab_pkg::LMS_C[l][0])
                + rlab_pkg::RESP_W'(pix[1]) * rlab_pkg::RESP_W'(rlab_pkg::LMS_C[l][1])
                + rlab_pkg::RESP_W'(pix[2]) * rlab_pkg::RESP_W'(rlab_pkg::LMS_C[l][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      resp_o <= resp_d;
    end
  end

  assign tag_o = tag_q;

endmodule
`default_nettype wire

// ----- rtl/rlab_log10.sv -----
// Three-lane log10 pipeline: normalise, 24 squaring stages, scale to log10.
`default_nettype none
module rlab_log10 (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  rlab_pkg::tag_t                         tag_i,
  input  wire  [2:0][rlab_pkg::RESP_W-1:0]       resp_i,
  output rlab_pkg::tag_t                         tag_o,
  output logic [2:0][rlab_pkg::LOG_W-1:0]        log_o
);

  localparam int NS = rlab_pkg::SQ_N + 1;

  logic [rlab_pkg::EXP_W-1:0]    e_n  [3];
  logic [rlab_pkg::MANT_W-1:0]   m_n  [3];
  logic [2*rlab_pkg::MANT_W-1:0] sq   [3][rlab_pkg::SQ_N];
  logic [rlab_pkg::MANT_W:0]     sq_t [3][rlab_pkg::SQ_N];

  logic [rlab_pkg::MANT_W-1:0]   m_q  [3][NS];
  logic [rlab_pkg::EXP_W-1:0]    e_q  [3][NS];
  logic [rlab_pkg::LOG_FRAC-1:0] f_q  [3][NS];
  logic                          z_q  [3][NS];
  rlab_pkg::tag_t                tag_q [NS+2];

  logic [rlab_pkg::L2_W+30:0]    p_q  [3];
  logic                          zp_q [3];
  logic [2:0][rlab_pkg::LOG_W-1:0] log_q;

  // leading-one search and normalisation
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      e_n[l] = '0;
      for (int i = 0; i < rlab_pkg::RESP_W; i++) begin
        if (resp_i[l][i]) e_n[l] = rlab_pkg::EXP_W'(i);
      end
      m_n[l] = rlab_pkg::MANT_W'(resp_i[l]) << (rlab_pkg::EXP_W'(30) - e_n[l]);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < rlab_pkg::SQ_N; s++) begin
        sq[l][s]   = (2*rlab_pkg::MANT_W)'(m_q[l][s]) * (2*rlab_pkg::MANT_W)'(m_q[l][s]);
        sq_t[l][s] = sq[l][s][2*rlab_pkg::MANT_W-1:30];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS + 2; s++) tag_q[s] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < NS + 2; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        m_q[l][0] <= m_n[l];
        e_q[l][0] <= e_n[l];
        f_q[l][0] <= '0;
        z_q[l][0] <= (resp_i[l] == '0);
        for (int s = 0; s < rlab_pkg::SQ_N; s++) begin
          // square; a carry into bit 31 sets the next fraction bit and halves
          if (sq_t[l][s][rlab_pkg::MANT_W]) begin
            m_q[l][s+1] <= sq_t[l][s][rlab_pkg::MANT_W:1];
          end else begin
            m_q[l][s+1] <= sq_t[l][s][rlab_pkg::MANT_W-1:0];
          end
          f_q[l][s+1] <= {f_q[l][s][rlab_pkg::LOG_FRAC-2:0], sq_t[l][s][rlab_pkg::MANT_W]};
          e_q[l][s+1] <= e_q[l][s];
          z_q[l][s+1] <= z_q[l][s];
        end
        p_q[l]  <= (rlab_pkg::L2_W+31)'({e_q[l][NS-1], f_q[l][NS-1]})
                 * (rlab_pkg::L2_W+31)'(rlab_pkg::LOG10_2_Q32);
        zp_q[l] <= z_q[l][NS-1];
        if (zp_q[l]) begin
          log_q[l] <= rlab_pkg::LOG_ZERO;
        end else begin
          log_q[l] <= p_q[l][rlab_pkg::L2_W+30:32] - rlab_pkg::LOG_OFFS;
        end
      end
    end
  end

  assign tag_o = tag_q[NS+1];
  assign log_o = log_q;

endmodule
`default_nettype wire

// ----- rtl/rlab_mix.sv -----
// Second matrix, rounding divide by 10000 * 2^k and output saturation.
`default_nettype none
module rlab_mix (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  rlab_pkg::tag_t                         tag_i,
  input  wire  [2:0][rlab_pkg::LOG_W-1:0]        log_i,
  output rlab_pkg::tag_t                         tag_o,
  output logic [2:0][rlab_pkg::Q_W-1:0]          res_o
);

  localparam int SW = rlab_pkg::SUM_W;
  localparam int PW = rlab_pkg::NQ_W + 30;

  rlab_pkg::tag_t              tag_q [6];

  logic signed [SW-1:0]        sl_q, sab_q, sd_q, c_q;
  logic signed [SW-1:0]        pl_q, pa1_q, pa2_q, pb_q;
  logic signed [SW-1:0]        s_q   [3];
  logic [SW-1:0]               mag   [3];
  logic [SW-1:0]               nsh   [3];
  logic [rlab_pkg::NQ_W-1:0]   n_q   [3];
  logic                        ng4_q [3];
  logic [PW-1:0]               prod  [3];
  logic [rlab_pkg::Q_W-1:0]    q_q   [3];
  logic                        ng5_q [3];
  logic [2:0][rlab_pkg::Q_W-1:0] res_q;
  logic signed [SW-1:0]        la, lb, lc;

  assign la = SW'($signed(log_i[0]));
  assign lb = SW'($signed(log_i[1]));
  assign lc = SW'($signed(log_i[2]));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = s_q[k][SW-1] ? SW'(-s_q[k]) : SW'(s_q[k]);
      nsh[k]  = (mag[k] + rlab_pkg::HALF_D) >> rlab_pkg::K_SHIFT;
      prod[k] = PW'(n_q[k]) * PW'(rlab_pkg::RCP_10000);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 6; s++) tag_q[s] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < 6; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sl_q  <= la + lb + lc;
      sab_q <= la + lb;
      sd_q  <= la - lb;
      c_q   <= lc;
      pl_q  <= sl_q  * SW'(rlab_pkg::C_L);
      pa1_q <= sab_q * SW'(rlab_pkg::C_A1);
      pa2_q <= c_q   * SW'(rlab_pkg::C_A2);
      pb_q  <= sd_q  * SW'(rlab_pkg::C_B);
      s_q[0] <= pl_q;
      s_q[1] <= pa1_q - pa2_q;
      s_q[2] <= pb_q;
      for (int k = 0; k < 3; k++) begin
        // quotients beyond 32768 saturate anyway
        n_q[k]   <= (nsh[k] > rlab_pkg::CAP_N) ? rlab_pkg::NQ_W'(rlab_pkg::CAP_N)
                                               : rlab_pkg::NQ_W'(nsh[k]);
        ng4_q[k] <= s_q[k][SW-1];
        q_q[k]   <= prod[k][PW-1:rlab_pkg::RCP_SH];
        ng5_q[k] <= ng4_q[k];
        if (tag_q[4].err) begin
          res_q[k] <= '0;
        end else if (ng5_q[k]) begin
          res_q[k] <= ~q_q[k] + rlab_pkg::Q_W'(1);
        end else if (q_q[k][rlab_pkg::Q_W-1]) begin
          res_q[k] <= {1'b0, {(rlab_pkg::Q_W-1){1'b1}}};
        end else begin
          res_q[k] <= q_q[k];
        end
      end
    end
  end

  assign tag_o = tag_q[5];
  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- rtl/rgb_to_lab_ruderman.sv -----
// Top level of the RGB to Ruderman l-alpha-beta conversion pipeline.
// Usage:
//   Input channel: in_valid_i with red_i, green_i, blue_i (signed 16 bit,
//   clamped to 0..255 inside) and undefined_i. A transfer happens on a rising
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with lightness_o, alpha_o, beta_o (signed,
//   FRAC_BITS fraction bits, saturating) and error_o. A transfer happens with
//   out_valid_o high and out_stall_i low.
//   An undefined pixel returns error_o = 1 and zero components.
// The path from input transfer to output runs through the clamp and LMS
//   matrix, then log10 (normalise, 24 squaring stages, one multiply, one
//   offset), then mixing, rounding divide and saturation, the last of them
//   the output register.
// Throughput is one pixel per clock while no result waits on out_stall_i; the squaring chain is fully pipelined.
// All stages share one enable: the whole pipeline holds while a result sits
// in the output register and out_stall_i is high, so in_stall_o follows
// out_stall_i in that case only. Bubbles flow through otherwise.
// Reset clears every valid bit; the pipeline is empty after reset.
`default_nettype none
module rgb_to_lab_ruderman (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [rlab_pkg::CH_W-1:0]       red_i,
  input  wire  [rlab_pkg::CH_W-1:0]       green_i,
  input  wire  [rlab_pkg::CH_W-1:0]       blue_i,
  input  wire                             undefined_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [rlab_pkg::Q_W-1:0]        lightness_o,
  output logic [rlab_pkg::Q_W-1:0]        alpha_o,
  output logic [rlab_pkg::Q_W-1:0]        beta_o,
  output logic                            error_o
);

  rlab_pkg::tag_t                         tag_in, tag_lms, tag_log, tag_out;
  logic [2:0][rlab_pkg::RESP_W-1:0]       resp;
  logic [2:0][rlab_pkg::LOG_W-1:0]        logv;
  logic [2:0][rlab_pkg::Q_W-1:0]          res;
  logic                                   en;

  // pipeline advances unless a result waits on a stalled receiver
  assign en         = !(tag_out.vld && out_stall_i);
  assign in_stall_o = !en;

  assign tag_in.vld = in_valid_i;
  assign tag_in.err = undefined_i;

  rlab_lms u_lms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_in),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .tag_o   (tag_lms),
    .resp_o  (resp)
  );

  rlab_log10 u_log10 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_lms),
    .resp_i (resp),
    .tag_o  (tag_log),
    .log_o  (logv)
  );

  rlab_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_log),
    .log_i  (logv),
    .tag_o  (tag_out),
    .res_o  (res)
  );

  assign out_valid_o = tag_out.vld;
  assign error_o     = tag_out.err;
  assign lightness_o = res[0];
  assign alpha_o     = res[1];
  assign beta_o      = res[2];

  // undefined pixel gives zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> lightness_o == '0 && alpha_o == '0 && beta_o == '0)
    else $error("error result with nonzero components");

  // input held back only by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // a blocked result is still there next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(error_o))
    else $error("blocked result lost");

endmodule
`default_nettype wire
